### sv/color_to_material_weights_core_macros.svh
// Assertion macros for the palette weighting core.
// Included by the top level; define NO_ASSERTIONS to compile them away.
`ifndef COLOR_TO_MATERIAL_WEIGHTS_CORE_MACROS_SVH
`define COLOR_TO_MATERIAL_WEIGHTS_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication.
`define CTMW_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ctmw assertion failed");
// Next-cycle implication.
`define CTMW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ctmw assertion failed");
`else
`define CTMW_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define CTMW_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

### sv/ctmw_pkg.sv
// Types, register codes and arithmetic step functions for the palette weighting core.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ctmw_pkg;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] REG_REF_COUNT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_REF_ENTRY_FIRST = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REF_ENTRY_LAST  = 3'd6;
    localparam logic [2:0] COUNT_RESET = 3'd1;

    // Distance arithmetic
    localparam int D2_W             = 18;             // squared distance
    localparam int DIST_SCALE_SHIFT = 16;
    localparam int SQ_V_W           = D2_W + DIST_SCALE_SHIFT;
    localparam int DIST_W           = 17;             // distance, Q.8
    localparam int SQ_STEPS         = DIST_W;
    localparam int SQ_REM_W         = 21;
    localparam int INV_W            = 25;             // reciprocal, Q.24
    localparam int RC_STEPS         = INV_W;
    localparam int RC_REM_W         = 18;
    localparam logic [RC_REM_W-1:0] RC_REM_INIT = 18'd128;  // top bits of 2^32
    localparam int STEPS_PER_STAGE  = 2;
    localparam int WEIGHT_W         = 17;

    typedef struct packed {
        logic [7:0] pixel_red;
        logic [7:0] pixel_green;
        logic [7:0] pixel_blue;
    } pixel_t;

    typedef struct packed {
        logic [7:0]          material_id;
        logic [WEIGHT_W-1:0] weight;
        logic                exact_match;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [7:0] mat;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } entry_t;

    typedef struct packed {
        logic [SQ_REM_W-1:0] rem;
        logic [DIST_W-1:0]   root;
    } sq_state_t;

    typedef struct packed {
        logic [RC_REM_W-1:0] rem;
        logic [INV_W-1:0]    num;
        logic [INV_W-1:0]    quot;
    } rc_state_t;

    // One digit of the integer square root
    function automatic sq_state_t sqrt_step(sq_state_t s, logic [1:0] pair);
        sq_state_t           o;
        logic [SQ_REM_W-1:0] r;
        logic [SQ_REM_W-1:0] t;
        r = {s.rem[SQ_REM_W-3:0], pair};
        t = SQ_REM_W'({s.root, 2'b01});
        if (r >= t)
        begin
            o.rem  = r - t;
            o.root = {s.root[DIST_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.root = {s.root[DIST_W-2:0], 1'b0};
        end
        return o;
    endfunction

    // One quotient bit of the reciprocal division
    function automatic rc_state_t recip_step(rc_state_t s, logic [DIST_W-1:0] q);
        rc_state_t           o;
        logic [RC_REM_W-1:0] r;
        r     = {s.rem[RC_REM_W-2:0], s.num[INV_W-1]};
        o.num = {s.num[INV_W-2:0], 1'b0};
        if (r >= RC_REM_W'(q))
        begin
            o.rem  = r - RC_REM_W'(q);
            o.quot = {s.quot[INV_W-2:0], 1'b1};
        end
        else
        begin
            o.rem  = r;
            o.quot = {s.quot[INV_W-2:0], 1'b0};
        end
        return o;
    endfunction

endpackage

`default_nettype wire

### sv/color_to_material_weights_core.sv
// Top level of the palette weighting core: config registers, reference sequencer,
// distance/root/reciprocal pipeline, per-pixel collector, normalizing divider pipeline.
// Depends on ctmw_pkg and color_to_material_weights_core_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "color_to_material_weights_core_macros.svh"

// A pixel is taken in one transaction and holds the input until its n references are
// issued, n being the active reference count (1..MAX_REFS): a sequencer issues one
// reference per cycle while the front pipeline advances, into a pipeline of squared
// distance (1 stage), square root (9 stages, two digits each) and reciprocal (13 stages,
// two bits each). A collector gathers the n reciprocals and their sum, then hands the
// pixel to a second sequencer that feeds one reference per cycle while the divider
// pipeline advances, into the normalizing divider (1 setup stage plus
// ceil((WEIGHT_FRAC_BITS+1)/2) stages). A pixel yields n results, or one on an exact match.
// The front pipeline holds only while the divider sequencer still works on the previous
// pixel; the divider pipeline holds only while the output register is stalled.
module color_to_material_weights_core #(
    parameter int MAX_REFS         = 6,
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  ctmw_pkg::pixel_t                   in_data,
    output logic                               out_valid,
    input  logic                               out_stall,
    output ctmw_pkg::result_t                  out_data,
    input  logic                               cfg_wen,
    input  logic [ctmw_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [ctmw_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import ctmw_pkg::*;

    localparam int IDX_W  = (MAX_REFS > 1) ? $clog2(MAX_REFS) : 1;
    localparam int CNT_W  = $clog2(MAX_REFS + 1);
    localparam int SUM_W  = INV_W + CNT_W;
    localparam int W      = WEIGHT_FRAC_BITS;
    localparam int NUM_W  = SUM_W + W + 1;
    localparam int SQ_STG = (SQ_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int RC_STG = (RC_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam int DV_STEPS = W + 1;
    localparam int DV_STG = (DV_STEPS + STEPS_PER_STAGE - 1) / STEPS_PER_STAGE;
    localparam logic [W:0] W_ONE = {1'b1, {W{1'b0}}};

    typedef struct packed {
        logic [7:0]       mat;
        logic [IDX_W-1:0] idx;
        logic             last;
        logic             exact;
    } side_t;

    typedef struct packed {
        logic [7:0] mat;
        logic       exact;
        logic       last;
    } be_side_t;

    typedef struct packed {
        logic [SUM_W-1:0] rem;
        logic [W:0]       num;
        logic [W:0]       quot;
    } dv_state_t;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [2:0] ref_count_reg;
    entry_t     entry_reg [MAX_REFS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ref_count_reg <= COUNT_RESET;
            for (int i = 0; i < MAX_REFS; i++)
            begin
                entry_reg[i] <= '0;
            end
        end
        else if (cfg_wen)
        begin
            if (cfg_index == REG_REF_COUNT)
            begin
                ref_count_reg <= cfg_data[2:0];
            end
            else if (cfg_index >= REG_REF_ENTRY_FIRST && cfg_index <= REG_REF_ENTRY_LAST)
            begin
                for (int i = 0; i < MAX_REFS; i++)
                begin
                    if ((int'(cfg_index) - int'(REG_REF_ENTRY_FIRST)) == i)
                    begin
                        entry_reg[i] <= entry_t'(cfg_data);
                    end
                end
            end
        end
    end

    // Clamp the count to 1..MAX_REFS, kept as the last index
    logic [IDX_W-1:0] last_idx;

    always_comb
    begin
        if (ref_count_reg == 3'd0)
        begin
            last_idx = '0;
        end
        else if (int'(ref_count_reg) > MAX_REFS)
        begin
            last_idx = IDX_W'(MAX_REFS - 1);
        end
        else
        begin
            last_idx = IDX_W'(ref_count_reg - 3'd1);
        end
    end

    // ------------------------------------------------------------------
    // Input register and reference sequencer
    // ------------------------------------------------------------------
    logic             pix_valid_reg;
    pixel_t           pix_reg;
    logic [IDX_W-1:0] iss_idx_reg;
    logic             fe_adv;
    logic             issue_fire;
    logic             iss_last;
    entry_t           cur_entry;

    assign issue_fire = pix_valid_reg && fe_adv;
    assign iss_last   = (iss_idx_reg == last_idx);
    assign in_stall   = pix_valid_reg && !(issue_fire && iss_last);
    assign cur_entry  = entry_reg[iss_idx_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix_valid_reg <= 1'b0;
            iss_idx_reg   <= '0;
        end
        else if (in_valid && !in_stall)
        begin
            pix_valid_reg <= 1'b1;
            iss_idx_reg   <= '0;
        end
        else if (issue_fire && iss_last)
        begin
            pix_valid_reg <= 1'b0;
        end
        else if (issue_fire)
        begin
            iss_idx_reg <= iss_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            pix_reg <= in_data;
        end
    end

    // ------------------------------------------------------------------
    // Squared distance stage
    // ------------------------------------------------------------------
    logic [7:0]      ad_r, ad_g, ad_b;
    logic [15:0]     sqr_r, sqr_g, sqr_b;
    logic [D2_W-1:0] d2_next;
    side_t           f0_side_next;
    logic            f0_valid_reg;
    side_t           f0_side_reg;
    logic [D2_W-1:0] f0_d2_reg;

    always_comb
    begin
        ad_r = (cur_entry.red > pix_reg.pixel_red) ? cur_entry.red - pix_reg.pixel_red
                                                   : pix_reg.pixel_red - cur_entry.red;
        ad_g = (cur_entry.green > pix_reg.pixel_green) ? cur_entry.green - pix_reg.pixel_green
                                                       : pix_reg.pixel_green - cur_entry.green;
        ad_b = (cur_entry.blue > pix_reg.pixel_blue) ? cur_entry.blue - pix_reg.pixel_blue
                                                     : pix_reg.pixel_blue - cur_entry.blue;
        sqr_r = {8'd0, ad_r} * {8'd0, ad_r};
        sqr_g = {8'd0, ad_g} * {8'd0, ad_g};
        sqr_b = {8'd0, ad_b} * {8'd0, ad_b};
        d2_next = D2_W'(sqr_r) + D2_W'(sqr_g) + D2_W'(sqr_b);
        f0_side_next.mat   = cur_entry.mat;
        f0_side_next.idx   = iss_idx_reg;
        f0_side_next.last  = iss_last;
        f0_side_next.exact = (ad_r == 8'd0) && (ad_g == 8'd0) && (ad_b == 8'd0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f0_valid_reg <= 1'b0;
        end
        else if (fe_adv)
        begin
            f0_valid_reg <= issue_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fe_adv)
        begin
            f0_side_reg <= f0_side_next;
            f0_d2_reg   <= d2_next;
        end
    end

    // ------------------------------------------------------------------
    // Square root stages: distance in Q.8
    // ------------------------------------------------------------------
    logic            sq_valid_reg [SQ_STG];
    side_t           sq_side_reg  [SQ_STG];
    logic [D2_W-1:0] sq_d2_reg    [SQ_STG];
    sq_state_t       sq_st_reg    [SQ_STG];
    sq_state_t       sq_st_next   [SQ_STG];

    genvar gs;
    for (gs = 0; gs < SQ_STG; gs++)
    begin : g_sq
        logic            v_in;
        side_t           s_in;
        logic [D2_W-1:0] d2_in;
        sq_state_t       st_in;

        if (gs == 0)
        begin : g_head
            assign v_in  = f0_valid_reg;
            assign s_in  = f0_side_reg;
            assign d2_in = f0_d2_reg;
            assign st_in = '0;
        end
        else
        begin : g_body
            assign v_in  = sq_valid_reg[gs-1];
            assign s_in  = sq_side_reg[gs-1];
            assign d2_in = sq_d2_reg[gs-1];
            assign st_in = sq_st_reg[gs-1];
        end

        // Run this stage's root digits
        always_comb
        begin
            sq_state_t         st;
            logic [SQ_V_W-1:0] v;
            int                k;
            st = st_in;
            v  = {d2_in, {DIST_SCALE_SHIFT{1'b0}}};
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                k = gs * STEPS_PER_STAGE + j;
                if (k < SQ_STEPS)
                begin
                    st = sqrt_step(st, v[SQ_V_W - 1 - 2 * k -: 2]);
                end
            end
            sq_st_next[gs] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                sq_valid_reg[gs] <= 1'b0;
            end
            else if (fe_adv)
            begin
                sq_valid_reg[gs] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (fe_adv)
            begin
                sq_side_reg[gs] <= s_in;
                sq_d2_reg[gs]   <= d2_in;
                sq_st_reg[gs]   <= sq_st_next[gs];
            end
        end
    end

    // ------------------------------------------------------------------
    // Reciprocal stages: rounded 2^32 / distance
    // ------------------------------------------------------------------
    logic              rc_valid_reg [RC_STG];
    side_t             rc_side_reg  [RC_STG];
    logic [DIST_W-1:0] rc_q_reg     [RC_STG];
    rc_state_t         rc_st_reg    [RC_STG];
    rc_state_t         rc_st_next   [RC_STG];

    genvar gr;
    for (gr = 0; gr < RC_STG; gr++)
    begin : g_rc
        logic              v_in;
        side_t             s_in;
        logic [DIST_W-1:0] q_in;
        rc_state_t         st_in;

        if (gr == 0)
        begin : g_head
            assign v_in        = sq_valid_reg[SQ_STG-1];
            assign s_in        = sq_side_reg[SQ_STG-1];
            assign q_in        = sq_st_reg[SQ_STG-1].root;
            assign st_in.rem   = RC_REM_INIT;
            assign st_in.num   = INV_W'(q_in >> 1);
            assign st_in.quot  = '0;
        end
        else
        begin : g_body
            assign v_in  = rc_valid_reg[gr-1];
            assign s_in  = rc_side_reg[gr-1];
            assign q_in  = rc_q_reg[gr-1];
            assign st_in = rc_st_reg[gr-1];
        end

        // Run this stage's quotient bits
        always_comb
        begin
            rc_state_t st;
            st = st_in;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (gr * STEPS_PER_STAGE + j < RC_STEPS)
                begin
                    st = recip_step(st, q_in);
                end
            end
            rc_st_next[gr] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                rc_valid_reg[gr] <= 1'b0;
            end
            else if (fe_adv)
            begin
                rc_valid_reg[gr] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (fe_adv)
            begin
                rc_side_reg[gr] <= s_in;
                rc_q_reg[gr]    <= q_in;
                rc_st_reg[gr]   <= rc_st_next[gr];
            end
        end
    end

    // ------------------------------------------------------------------
    // Collector: gather reciprocals and their sum for one pixel
    // ------------------------------------------------------------------
    logic             tail_valid;
    side_t            tail_side;
    logic [INV_W-1:0] tail_inv;
    logic             col_we;
    logic             col_hand;
    logic             col_first;
    logic [SUM_W-1:0] col_sum_next;
    logic             col_exact_next;
    logic [7:0]       col_xmat_next;
    logic [INV_W-1:0] col_inv_reg [MAX_REFS];
    logic [7:0]       col_mat_reg [MAX_REFS];
    logic [SUM_W-1:0] col_sum_reg;
    logic             col_exact_reg;
    logic [7:0]       col_xmat_reg;

    logic             nb_valid_reg;
    logic [INV_W-1:0] nb_inv_reg [MAX_REFS];
    logic [7:0]       nb_mat_reg [MAX_REFS];
    logic [SUM_W-1:0] nb_sum_reg;
    logic             nb_exact_reg;
    logic [7:0]       nb_xmat_reg;
    logic [IDX_W-1:0] nb_last_reg;

    assign tail_valid = rc_valid_reg[RC_STG-1];
    assign tail_side  = rc_side_reg[RC_STG-1];
    assign tail_inv   = rc_st_reg[RC_STG-1].quot;

    // Hold the front pipeline while a finished pixel cannot be handed over
    assign fe_adv   = !(tail_valid && tail_side.last && nb_valid_reg);
    assign col_we   = tail_valid && fe_adv;
    assign col_hand = col_we && tail_side.last;

    always_comb
    begin
        col_first      = (tail_side.idx == '0);
        col_sum_next   = (col_first ? '0 : col_sum_reg) + SUM_W'(tail_inv);
        col_exact_next = col_first ? 1'b0 : col_exact_reg;
        col_xmat_next  = col_xmat_reg;
        // Keep the first exact match in entry order
        if (tail_side.exact && !col_exact_next)
        begin
            col_exact_next = 1'b1;
            col_xmat_next  = tail_side.mat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_we)
        begin
            col_sum_reg   <= col_sum_next;
            col_exact_reg <= col_exact_next;
            col_xmat_reg  <= col_xmat_next;
            for (int i = 0; i < MAX_REFS; i++)
            begin
                if (tail_side.idx == IDX_W'(i))
                begin
                    col_inv_reg[i] <= tail_inv;
                    col_mat_reg[i] <= tail_side.mat;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Normalize buffer and divider sequencer
    // ------------------------------------------------------------------
    logic             be_adv;
    logic             be_fire;
    logic             be_last;
    logic [IDX_W-1:0] be_idx_reg;

    assign be_fire = nb_valid_reg && be_adv;
    assign be_last = nb_exact_reg || (be_idx_reg == nb_last_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nb_valid_reg <= 1'b0;
            be_idx_reg   <= '0;
        end
        else if (col_hand)
        begin
            nb_valid_reg <= 1'b1;
            be_idx_reg   <= '0;
        end
        else if (be_fire && be_last)
        begin
            nb_valid_reg <= 1'b0;
        end
        else if (be_fire)
        begin
            be_idx_reg <= be_idx_reg + IDX_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (col_hand)
        begin
            nb_sum_reg   <= col_sum_next;
            nb_exact_reg <= col_exact_next;
            nb_xmat_reg  <= col_xmat_next;
            nb_last_reg  <= tail_side.idx;
            for (int i = 0; i < MAX_REFS; i++)
            begin
                if (tail_side.idx == IDX_W'(i))
                begin
                    nb_inv_reg[i] <= tail_inv;
                    nb_mat_reg[i] <= tail_side.mat;
                end
                else
                begin
                    nb_inv_reg[i] <= col_inv_reg[i];
                    nb_mat_reg[i] <= col_mat_reg[i];
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Divider setup stage: numerator inv * 2^W + sum / 2
    // ------------------------------------------------------------------
    logic             b0_valid_reg;
    be_side_t         b0_side_reg;
    logic [SUM_W-1:0] b0_sum_reg;
    dv_state_t        b0_st_reg;
    logic [NUM_W-1:0] b0_numer;
    be_side_t         b0_side_next;

    always_comb
    begin
        b0_numer = (NUM_W'(nb_inv_reg[be_idx_reg]) << W) + NUM_W'(nb_sum_reg >> 1);
        b0_side_next.mat   = nb_exact_reg ? nb_xmat_reg : nb_mat_reg[be_idx_reg];
        b0_side_next.exact = nb_exact_reg;
        b0_side_next.last  = be_last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b0_valid_reg <= 1'b0;
        end
        else if (be_adv)
        begin
            b0_valid_reg <= be_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        if (be_adv)
        begin
            b0_side_reg    <= b0_side_next;
            b0_sum_reg     <= nb_sum_reg;
            b0_st_reg.rem  <= b0_numer[NUM_W-1:W+1];
            b0_st_reg.num  <= b0_numer[W:0];
            b0_st_reg.quot <= '0;
        end
    end

    // ------------------------------------------------------------------
    // Divider stages: rounded weight quotient
    // ------------------------------------------------------------------
    logic             dv_valid_reg [DV_STG];
    be_side_t         dv_side_reg  [DV_STG];
    logic [SUM_W-1:0] dv_sum_reg   [DV_STG];
    dv_state_t        dv_st_reg    [DV_STG];
    dv_state_t        dv_st_next   [DV_STG];

    genvar gd;
    for (gd = 0; gd < DV_STG; gd++)
    begin : g_dv
        logic             v_in;
        be_side_t         s_in;
        logic [SUM_W-1:0] sum_in;
        dv_state_t        st_in;

        if (gd == 0)
        begin : g_head
            assign v_in   = b0_valid_reg;
            assign s_in   = b0_side_reg;
            assign sum_in = b0_sum_reg;
            assign st_in  = b0_st_reg;
        end
        else
        begin : g_body
            assign v_in   = dv_valid_reg[gd-1];
            assign s_in   = dv_side_reg[gd-1];
            assign sum_in = dv_sum_reg[gd-1];
            assign st_in  = dv_st_reg[gd-1];
        end

        // Run this stage's quotient bits
        always_comb
        begin
            dv_state_t      st;
            logic [SUM_W:0] r;
            st = st_in;
            for (int j = 0; j < STEPS_PER_STAGE; j++)
            begin
                if (gd * STEPS_PER_STAGE + j < DV_STEPS)
                begin
                    r      = {st.rem, st.num[W]};
                    st.num = st.num << 1;
                    if (r >= {1'b0, sum_in})
                    begin
                        st.rem  = SUM_W'(r - {1'b0, sum_in});
                        st.quot = {st.quot[W-1:0], 1'b1};
                    end
                    else
                    begin
                        st.rem  = SUM_W'(r);
                        st.quot = {st.quot[W-1:0], 1'b0};
                    end
                end
            end
            dv_st_next[gd] = st;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                dv_valid_reg[gd] <= 1'b0;
            end
            else if (be_adv)
            begin
                dv_valid_reg[gd] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (be_adv)
            begin
                dv_side_reg[gd] <= s_in;
                dv_sum_reg[gd]  <= sum_in;
                dv_st_reg[gd]   <= dv_st_next[gd];
            end
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic     out_valid_reg;
    result_t  out_data_reg;
    result_t  out_data_next;
    be_side_t dv_tail_side;

    assign be_adv       = !out_valid_reg || !out_stall;
    assign dv_tail_side = dv_side_reg[DV_STG-1];

    always_comb
    begin
        out_data_next.material_id = dv_tail_side.mat;
        out_data_next.weight      = dv_tail_side.exact ? WEIGHT_W'(W_ONE)
                                                       : WEIGHT_W'(dv_st_reg[DV_STG-1].quot);
        out_data_next.exact_match = dv_tail_side.exact;
        out_data_next.last        = dv_tail_side.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (be_adv)
        begin
            out_valid_reg <= dv_valid_reg[DV_STG-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (be_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `CTMW_ASSERT_IMP(a_exact_is_last, clk, rst_n, out_valid && out_data.exact_match, out_data.last)
    `CTMW_ASSERT_IMP(a_hand_free, clk, rst_n, col_hand, !nb_valid_reg)
    `CTMW_ASSERT_NEXT(a_hand_loads, clk, rst_n, col_hand, nb_valid_reg)
    `CTMW_ASSERT_IMP(a_front_hold_cause, clk, rst_n, !fe_adv, nb_valid_reg && tail_valid)

endmodule

`default_nettype wire
